[hw/rtl/tcl_pkg.sv]
`default_nettype none
package tcl_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int LEVEL_WIDTH = 16;
  localparam int SUM_WIDTH   = LEVEL_WIDTH + 2;
  localparam int CNT_WIDTH   = $clog2(CODE_LENGTH + 1);
  localparam int CODE_SYMS   = 4;
  localparam int NUM_LANES   = 3;

  localparam int SYM_TH_WIDTH   = 16;
  localparam int NOISE_TH_WIDTH = 18;
  localparam int CODE_WIDTH     = 8;
  localparam int CFG_DATA_WIDTH = 18;
  localparam int CFG_IDX_WIDTH  = 3;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SYMBOL_TH = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NOISE_TH  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OPEN_CODE = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CLOSE_CODE = 3'd3;

  localparam logic [SYM_TH_WIDTH-1:0]   SYMBOL_TH_RST  = 16'd1000;
  localparam logic [NOISE_TH_WIDTH-1:0] NOISE_TH_RST   = 18'd25000;
  localparam logic [CODE_WIDTH-1:0]     OPEN_CODE_RST  = 8'd145;
  localparam logic [CODE_WIDTH-1:0]     CLOSE_CODE_RST = 8'd36;

  localparam logic [1:0] SYM_NONE = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_VALIDATE = 3'd1,
    PH_OPEN     = 3'd2,
    PH_CLOSE    = 3'd3,
    PH_ERROR    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] level_a;
    logic [LEVEL_WIDTH-1:0] level_b;
    logic [LEVEL_WIDTH-1:0] level_c;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic                 symbol_valid;
    logic [1:0]           symbol_value;
    logic [CNT_WIDTH-1:0] symbols_held;
    logic                 door_open;
    logic                 error_pulse;
  } out_beat_t;

  // What the lane merge found for one sample.
  typedef struct packed {
    logic       hit;
    logic [1:0] sym;
    logic       loud;
  } det_t;

endpackage
`default_nettype wire

[hw/rtl/tcl_lane.sv]
`default_nettype none
module tcl_lane
  import tcl_pkg::*;
(
  input  wire logic [LEVEL_WIDTH-1:0]  level_self,
  input  wire logic [LEVEL_WIDTH-1:0]  level_o1,
  input  wire logic [LEVEL_WIDTH-1:0]  level_o2,
  input  wire logic [SYM_TH_WIDTH-1:0] symbol_th,
  output logic                         hit
);

  logic [LEVEL_WIDTH-1:0] th_ext;

  always_comb begin
    if (LEVEL_WIDTH >= SYM_TH_WIDTH) begin
      th_ext = LEVEL_WIDTH'(symbol_th);
    end else begin
      // A threshold beyond the level range can never be exceeded.
      th_ext = (symbol_th >> LEVEL_WIDTH) != '0 ? '1 : LEVEL_WIDTH'(symbol_th);
    end
  end

  // A channel wins only as a strict maximum above the threshold.
  always_comb begin
    hit = (level_self > th_ext) && (level_self > level_o1) && (level_self > level_o2);
    if (LEVEL_WIDTH < SYM_TH_WIDTH && (symbol_th >> LEVEL_WIDTH) != '0) begin
      hit = 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tcl_merge.sv]
`default_nettype none
module tcl_merge
  import tcl_pkg::*;
(
  input  wire logic [NUM_LANES-1:0]      lane_hit,
  input  wire in_beat_t                  levels,
  input  wire logic [NOISE_TH_WIDTH-1:0] noise_th,
  output det_t                           det
);

  logic [SUM_WIDTH-1:0] sum;

  always_comb begin
    sum = SUM_WIDTH'(levels.level_a) + SUM_WIDTH'(levels.level_b)
        + SUM_WIDTH'(levels.level_c);
    det.loud = (SUM_WIDTH + 1)'(sum) > (SUM_WIDTH + 1)'(noise_th);
    det.hit  = |lane_hit;
    if (lane_hit[0]) begin
      det.sym = 2'd0;
    end else if (lane_hit[1]) begin
      det.sym = 2'd1;
    end else if (lane_hit[2]) begin
      det.sym = 2'd2;
    end else begin
      det.sym = 2'd0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tcl_ctrl.sv]
`default_nettype none
module tcl_ctrl
  import tcl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire det_t                  det,
  input  wire logic [CODE_WIDTH-1:0] open_code,
  input  wire logic [CODE_WIDTH-1:0] close_code,
  output out_beat_t                  result
);

  phase_t               phase_r, phase_nxt;
  logic [1:0]           store_r [CODE_LENGTH];
  logic [1:0]           store_nxt [CODE_LENGTH];
  logic [CNT_WIDTH-1:0] count_r, count_nxt;
  logic                 quiet_r, quiet_nxt;
  logic                 door_r, door_nxt;
  logic                 open_match, close_match;
  logic                 take_sym;
  logic [1:0]           want_open, want_close;

  always_comb begin
    open_match  = 1'b1;
    close_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      want_open  = 2'd0;
      want_close = 2'd0;
      if (i < CODE_SYMS) begin
        want_open  = open_code[(2*i) +: 2];
        want_close = close_code[(2*i) +: 2];
      end
      if (store_r[i] != want_open)  open_match  = 1'b0;
      if (store_r[i] != want_close) close_match = 1'b0;
    end
  end

  assign take_sym = quiet_r && det.hit && (count_r < CNT_WIDTH'(CODE_LENGTH));

  // Next phase.
  always_comb begin
    case (phase_r)
      PH_WAIT: begin
        if (take_sym && (count_r == CNT_WIDTH'(CODE_LENGTH - 1))) begin
          phase_nxt = PH_VALIDATE;
        end else if (count_r >= CNT_WIDTH'(CODE_LENGTH)) begin
          phase_nxt = PH_VALIDATE;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_VALIDATE: begin
        if (open_match) begin
          phase_nxt = PH_OPEN;
        end else if (close_match) begin
          phase_nxt = PH_CLOSE;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
  end

  // Datapath updates and the result of this step.
  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    quiet_nxt = quiet_r;
    door_nxt  = door_r;
    result    = '0;
    case (phase_r)
      PH_WAIT: begin
        if (take_sym) begin
          // A symbol is only taken while the store has room.
          store_nxt[count_r[$clog2(CODE_LENGTH)-1:0]] = det.sym;
          count_nxt           = count_r + 1'b1;
          result.symbol_valid = 1'b1;
          result.symbol_value = det.sym;
        end
        quiet_nxt = !det.loud;
      end
      PH_VALIDATE: begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
          store_nxt[i] = SYM_NONE;
        end
        count_nxt = '0;
      end
      PH_OPEN:  door_nxt = 1'b1;
      PH_CLOSE: door_nxt = 1'b0;
      PH_ERROR: result.error_pulse = 1'b1;
      default: ;
    endcase
    result.phase        = phase_nxt;
    result.symbols_held = count_nxt;
    result.door_open    = door_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      count_r <= '0;
      quiet_r <= 1'b1;
      door_r  <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        store_r[i] <= SYM_NONE;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      quiet_r <= quiet_nxt;
      door_r  <= door_nxt;
      store_r <= store_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tone_code_lock_fsm.sv]
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data   (three channel levels)
// out     | output    | out_valid/out_stall| out_data  (phase, symbol, door, error)
// cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// One sample is taken per clock while in_stall is low; each result is registered.
// The lock state steps in the same cycle the sample is accepted, with the three
// comparison lanes and the merge in front of it.
// A two-entry output register and skid stage keep input flowing for one beat
// while the output is stalled; in_stall rises only when both entries are full.
// rst_n is synchronous; all configuration registers return to their defaults.
module tone_code_lock_fsm
  import tcl_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_beat_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_beat_t                      out_data,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  logic [SYM_TH_WIDTH-1:0]   symbol_th_r;
  logic [NOISE_TH_WIDTH-1:0] noise_th_r;
  logic [CODE_WIDTH-1:0]     open_code_r;
  logic [CODE_WIDTH-1:0]     close_code_r;

  logic [NUM_LANES-1:0] lane_hit;
  det_t                 det;
  out_beat_t            result;
  logic                 accept, out_take;

  out_beat_t out_data_r, skid_data_r;
  logic      out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_th_r  <= SYMBOL_TH_RST;
      noise_th_r   <= NOISE_TH_RST;
      open_code_r  <= OPEN_CODE_RST;
      close_code_r <= CLOSE_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SYMBOL_TH:  symbol_th_r  <= cfg_wdata[SYM_TH_WIDTH-1:0];
        REG_NOISE_TH:   noise_th_r   <= cfg_wdata[NOISE_TH_WIDTH-1:0];
        REG_OPEN_CODE:  open_code_r  <= cfg_wdata[CODE_WIDTH-1:0];
        REG_CLOSE_CODE: close_code_r <= cfg_wdata[CODE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  tcl_lane u_lane0 (
    .level_self (in_data.level_a),
    .level_o1   (in_data.level_b),
    .level_o2   (in_data.level_c),
    .symbol_th  (symbol_th_r),
    .hit        (lane_hit[0])
  );

  tcl_lane u_lane1 (
    .level_self (in_data.level_b),
    .level_o1   (in_data.level_a),
    .level_o2   (in_data.level_c),
    .symbol_th  (symbol_th_r),
    .hit        (lane_hit[1])
  );

  tcl_lane u_lane2 (
    .level_self (in_data.level_c),
    .level_o1   (in_data.level_a),
    .level_o2   (in_data.level_b),
    .symbol_th  (symbol_th_r),
    .hit        (lane_hit[2])
  );

  tcl_merge u_merge (
    .lane_hit (lane_hit),
    .levels   (in_data),
    .noise_th (noise_th_r),
    .det      (det)
  );

  tcl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .det        (det),
    .open_code  (open_code_r),
    .close_code (close_code_r),
    .result     (result)
  );

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
      end
    end else begin
      skid_valid_nxt = skid_valid_r || accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // A beat that cannot go straight to the output register parks in the skid entry.
  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hw/rtl/tcl_checker.sv]
`default_nettype none
module tcl_checker
  import tcl_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);

  // Nothing is offered on the output in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // A sample taken while the output is stalled fills the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && out_valid && out_stall |=> in_stall)
    else $error("skid entry did not hold a beat taken under stall");

  a_validate_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.phase == PH_VALIDATE |->
      out_data.symbol_valid && out_data.symbols_held == CNT_WIDTH'(CODE_LENGTH))
    else $error("validate step without a full store");

  a_error_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_pulse |->
      out_data.phase == PH_WAIT && !out_data.symbol_valid && out_data.symbols_held == '0)
    else $error("error pulse outside an error step");

endmodule

bind tone_code_lock_fsm tcl_checker u_tcl_checker (.*);
`default_nettype wire
